// ----- src/jpp_pkg.sv -----
package jpp_pkg;

    localparam int MaxDepth = 7;

    localparam int LvlW = 3;
    localparam int CntW = 5;
    localparam int TotW = 6;
    localparam int PcW  = 4;

    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChQuote   = 8'h22;
    localparam logic [7:0] ChComma   = 8'h2C;
    localparam logic [7:0] ChColon   = 8'h3A;
    localparam logic [7:0] ChLbrack  = 8'h5B;
    localparam logic [7:0] ChBslash  = 8'h5C;
    localparam logic [7:0] ChRbrack  = 8'h5D;
    localparam logic [7:0] ChLbrace  = 8'h7B;
    localparam logic [7:0] ChRbrace  = 8'h7D;

    typedef enum logic [1:0] {
        K_CHAR,
        K_COLON,
        K_COMMA,
        K_CLOSE
    } kind_t;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_PRE,
        OP_POST,
        OP_CHR,
        OP_SP1,
        OP_NL,
        OP_SPC
    } op_t;

    typedef enum logic [1:0] {
        LV_PRE,
        LV_MAIN,
        LV_POST
    } lvsel_t;

    typedef struct packed {
        op_t            op;
        lvsel_t         lvl;
        logic           disp;
        logic [PcW-1:0] tgt;
    } uword_t;

    typedef struct packed {
        logic [7:0]      ch;
        kind_t           kind;
        logic            pre;
        logic [LvlW-1:0] pre_lvl;
        logic [LvlW-1:0] main_lvl;
        logic            post;
        logic [LvlW-1:0] post_lvl;
        logic            ovf;
        logic [TotW-1:0] total;
    } item_t;

    localparam logic [PcW-1:0] PcWait  = 4'd0;
    localparam logic [PcW-1:0] PcPre   = 4'd1;
    localparam logic [PcW-1:0] PcChar  = 4'd4;
    localparam logic [PcW-1:0] PcColon = 4'd5;
    localparam logic [PcW-1:0] PcColSp = 4'd6;
    localparam logic [PcW-1:0] PcComma = 4'd7;
    localparam logic [PcW-1:0] PcClose = 4'd10;
    localparam logic [PcW-1:0] PcClChr = 4'd12;
    localparam logic [PcW-1:0] PcPost  = 4'd13;

    function automatic uword_t ucode(input logic [PcW-1:0] pc);
        uword_t w;
        w = '{OP_WAIT, LV_PRE, 1'b0, PcPre};
        case (pc)
            4'd0:    w = '{OP_WAIT, LV_PRE,  1'b0, PcPre};
            4'd1:    w = '{OP_PRE,  LV_PRE,  1'b1, PcWait};
            4'd2:    w = '{OP_NL,   LV_PRE,  1'b1, PcWait};
            4'd3:    w = '{OP_SPC,  LV_PRE,  1'b1, PcWait};
            4'd4:    w = '{OP_CHR,  LV_MAIN, 1'b0, PcPost};
            4'd5:    w = '{OP_CHR,  LV_MAIN, 1'b0, PcColSp};
            4'd6:    w = '{OP_SP1,  LV_MAIN, 1'b0, PcPost};
            4'd7:    w = '{OP_CHR,  LV_MAIN, 1'b0, 4'd8};
            4'd8:    w = '{OP_NL,   LV_MAIN, 1'b0, PcPost};
            4'd9:    w = '{OP_SPC,  LV_MAIN, 1'b0, PcPost};
            4'd10:   w = '{OP_NL,   LV_MAIN, 1'b0, PcClChr};
            4'd11:   w = '{OP_SPC,  LV_MAIN, 1'b0, PcClChr};
            4'd12:   w = '{OP_CHR,  LV_MAIN, 1'b0, PcPost};
            4'd13:   w = '{OP_POST, LV_POST, 1'b0, PcWait};
            4'd14:   w = '{OP_NL,   LV_POST, 1'b0, PcWait};
            4'd15:   w = '{OP_SPC,  LV_POST, 1'b0, PcWait};
            default: w = '{OP_WAIT, LV_PRE,  1'b0, PcPre};
        endcase
        return w;
    endfunction

    function automatic logic [PcW-1:0] entry(input kind_t k);
        logic [PcW-1:0] a;
        case (k)
            K_CHAR:  a = PcChar;
            K_COLON: a = PcColon;
            K_COMMA: a = PcComma;
            K_CLOSE: a = PcClose;
            default: a = PcChar;
        endcase
        return a;
    endfunction

    // Newline plus four spaces per level.
    function automatic logic [TotW-1:0] run_len(input logic [LvlW-1:0] lvl);
        return {1'b0, lvl, 2'b00} + TotW'(1);
    endfunction

endpackage

// ----- src/json_pretty_printer.sv -----
// Channel   Direction  Payload
// s_*       in         tdata: in_byte[7:0]; tlast: stream_end
// m_*       out        tdata: out_byte[7:0]; tlast: run_last; tuser: depth_overflow
//
// A request runs three control steps plus one emitting step per output character,
// and the longest request emits 59 characters.
// The microcode sequencer emits at most one character per step.
// Reset clears the nesting state, the sequencer and the output valid flag.
// While the output register is full and m_tready is low, the sequencer holds on
// its emitting step.
module json_pretty_printer
    import jpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast,
    output logic       m_tuser    // depth_overflow
);

    item_t item;
    logic  take;

    assign take = s_tvalid && s_tready;

    jpp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (s_tdata),
        .in_end  (s_tlast),
        .take    (take),
        .item    (item)
    );

    jpp_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item_in   (item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_flag  (m_tuser)
    );

endmodule

// ----- src/jpp_front.sv -----
module jpp_front
    import jpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    input  logic       take,
    output item_t      item
);

    logic            inside_reg, inside_next;
    logic [7:0]      prev_reg, prev_next;
    logic [LvlW-1:0] depth_reg, depth_next;
    logic            pend_reg, pend_next;
    logic            ovf_reg, ovf_next;

    logic            collapse;
    logic [TotW-1:0] pre_len, main_len, post_len;

    always_comb
    begin
        inside_next   = inside_reg;
        depth_next    = depth_reg;
        pend_next     = pend_reg;
        ovf_next      = ovf_reg;
        prev_next     = in_byte;
        item.ch       = in_byte;
        item.kind     = K_CHAR;
        item.pre      = 1'b0;
        item.pre_lvl  = depth_reg;
        item.main_lvl = depth_reg;
        collapse      = pend_reg &&
                        ((in_byte == ChRbrace && prev_reg == ChLbrace) ||
                         (in_byte == ChRbrack && prev_reg == ChLbrack));
        if (inside_reg)
        begin
            if (in_byte == ChQuote && prev_reg != ChBslash)
            begin
                inside_next = 1'b0;
            end
        end
        else if (collapse)
        begin
            pend_next = 1'b0;
            if (depth_reg != '0)
            begin
                depth_next = depth_reg - LvlW'(1);
            end
        end
        else
        begin
            item.pre  = pend_reg;
            pend_next = 1'b0;
            case (in_byte)
                ChLbrace, ChLbrack:
                begin
                    if (depth_reg >= LvlW'(MaxDepth))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        depth_next = depth_reg + LvlW'(1);
                    end
                    pend_next = 1'b1;
                end
                ChComma:
                begin
                    item.kind = K_COMMA;
                end
                ChRbrace, ChRbrack:
                begin
                    item.kind = K_CLOSE;
                    if (depth_reg == '0)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        depth_next = depth_reg - LvlW'(1);
                    end
                    item.main_lvl = depth_next;
                end
                ChQuote:
                begin
                    inside_next = 1'b1;
                end
                ChColon:
                begin
                    item.kind = K_COLON;
                end
                default:
                begin
                    item.kind = K_CHAR;
                end
            endcase
        end
        item.post     = in_end && pend_next;
        item.post_lvl = depth_next;
        item.ovf      = ovf_next;

        pre_len = item.pre ? run_len(item.pre_lvl) : '0;
        case (item.kind)
            K_CHAR:  main_len = TotW'(1);
            K_COLON: main_len = TotW'(2);
            K_COMMA: main_len = run_len(item.main_lvl) + TotW'(1);
            K_CLOSE: main_len = run_len(item.main_lvl) + TotW'(1);
            default: main_len = TotW'(1);
        endcase
        post_len   = item.post ? run_len(item.post_lvl) : '0;
        item.total = pre_len + main_len + post_len;

        if (in_end)
        begin
            inside_next = 1'b0;
            prev_next   = '0;
            depth_next  = '0;
            pend_next   = 1'b0;
            ovf_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            prev_reg   <= '0;
            depth_reg  <= '0;
            pend_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (take)
        begin
            inside_reg <= inside_next;
            prev_reg   <= prev_next;
            depth_reg  <= depth_next;
            pend_reg   <= pend_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

// ----- src/jpp_seq.sv -----
module jpp_seq
    import jpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  item_t      item_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_flag
);

    logic [PcW-1:0]  pc_reg, pc_next;
    item_t           item_reg, item_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [TotW-1:0] rem_reg, rem_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_byte_reg, m_byte_next;
    logic            m_last_reg, m_last_next;
    logic            m_flag_reg, m_flag_next;

    uword_t          uw;
    logic [LvlW-1:0] lvl;
    logic [PcW-1:0]  target;
    logic            out_free;
    logic            emit;
    logic [7:0]      emit_byte;

    always_comb
    begin
        uw       = ucode(pc_reg);
        target   = uw.disp ? entry(item_reg.kind) : uw.tgt;
        out_free = !m_valid_reg || out_ready;
        case (uw.lvl)
            LV_PRE:  lvl = item_reg.pre_lvl;
            LV_MAIN: lvl = item_reg.main_lvl;
            LV_POST: lvl = item_reg.post_lvl;
            default: lvl = item_reg.main_lvl;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        item_next = item_reg;
        cnt_next  = cnt_reg;
        in_ready  = 1'b0;
        emit      = 1'b0;
        emit_byte = ChSpace;
        case (uw.op)
            OP_WAIT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = item_in;
                    pc_next   = uw.tgt;
                end
            end
            OP_PRE:
            begin
                pc_next = item_reg.pre ? pc_reg + PcW'(1) : target;
            end
            OP_POST:
            begin
                pc_next = item_reg.post ? pc_reg + PcW'(1) : target;
            end
            OP_CHR:
            begin
                emit_byte = item_reg.ch;
                if (out_free)
                begin
                    emit    = 1'b1;
                    pc_next = target;
                end
            end
            OP_SP1:
            begin
                if (out_free)
                begin
                    emit    = 1'b1;
                    pc_next = target;
                end
            end
            OP_NL:
            begin
                emit_byte = ChNewline;
                if (out_free)
                begin
                    emit     = 1'b1;
                    cnt_next = {lvl, 2'b00};
                    pc_next  = (lvl == '0) ? target : pc_reg + PcW'(1);
                end
            end
            OP_SPC:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    cnt_next = cnt_reg - CntW'(1);
                    pc_next  = (cnt_reg == CntW'(1)) ? target : pc_reg;
                end
            end
            default:
            begin
                pc_next = PcWait;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_flag_next  = m_flag_reg;
        rem_next     = rem_reg;
        if (uw.op == OP_WAIT && in_valid)
        begin
            rem_next = item_in.total;
        end
        if (emit)
        begin
            m_valid_next = 1'b1;
            m_byte_next  = emit_byte;
            m_last_next  = (rem_reg == TotW'(1));
            m_flag_next  = item_reg.ovf;
            rem_next     = rem_reg - TotW'(1);
        end
        else if (out_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= PcWait;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_flag_reg <= m_flag_next;
    end

    assign out_valid = m_valid_reg;
    assign out_byte  = m_byte_reg;
    assign out_last  = m_last_reg;
    assign out_flag  = m_flag_reg;

endmodule
